/* hw/rtl/fop_pkg.sv */
package fop_pkg;

  localparam int unsigned MaxSide = 1024;
  localparam int unsigned SideW   = 11;
  localparam int unsigned PosW    = 10;
  localparam int unsigned DiffW   = 12;
  localparam int unsigned SqW     = 22;
  localparam int unsigned SumW    = 23;

  localparam logic [SideW-1:0] MaxSideVal = SideW'(MaxSide);

  // register indexes
  typedef enum logic [1:0] {
    REG_SIDE  = 2'd0,
    REG_SHAPE = 2'd1,
    REG_COLOR = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    SHAPE_NONE    = 3'd0,
    SHAPE_SQUARE  = 3'd1,
    SHAPE_CIRCLE  = 3'd2,
    SHAPE_RINGS   = 3'd3,
    SHAPE_ROUNDED = 3'd4
  } shape_e;

  typedef enum logic [2:0] {
    COL_RED   = 3'd0,
    COL_GREEN = 3'd1,
    COL_WHITE = 3'd2,
    COL_BLUE  = 3'd3,
    COL_BLACK = 3'd4,
    COL_BROWN = 3'd5
  } color_e;

  // difference slots
  localparam int unsigned D_XC = 0;
  localparam int unsigned D_YC = 1;
  localparam int unsigned D_XQ = 2;
  localparam int unsigned D_XT = 3;
  localparam int unsigned D_YQ = 4;
  localparam int unsigned D_YT = 5;
  localparam int unsigned D_X  = 6;
  localparam int unsigned D_Y  = 7;
  localparam int unsigned D_SX = 8;
  localparam int unsigned D_SY = 9;
  localparam int unsigned NumD = 10;

  typedef struct packed {
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
    logic [7:0]      red_in;
    logic [7:0]      green_in;
    logic [7:0]      blue_in;
    logic [7:0]      alpha_in;
  } in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } out_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pix_t;

  typedef struct packed {
    logic [SideW-1:0] side;   // clamped
    logic [2:0]       shape;
    logic [2:0]       color;
    logic [SqW-1:0]   circ2;  // (c-1)^2
    logic [SqW-1:0]   lo2;    // (q-5)^2
    logic [SqW-1:0]   q2;     // q^2
    logic [SqW-1:0]   arc2;   // (q+20)^2
  } cfg_t;

  typedef struct packed {
    pix_t       pix;
    logic       in_img;
    logic       sq_hit;
    logic       circ_hit;
    logic       ring_hit;
    logic [3:0] kcut;
    logic [3:0] kpaint;
    logic [3:0] bar;
  } flags_t;

  function automatic logic [SqW-1:0] sq_abs(input logic signed [DiffW-1:0] v);
    logic [DiffW-1:0] m;
    m = v[DiffW-1] ? DiffW'(-v) : DiffW'(v);
    return SqW'(m[DiffW-2:0]) * SqW'(m[DiffW-2:0]);
  endfunction

  function automatic logic [23:0] color_rgb(input logic [2:0] sel);
    logic [23:0] c;
    case (sel)
      COL_RED:   c = {8'd255, 8'd0, 8'd0};
      COL_GREEN: c = {8'd0, 8'd255, 8'd0};
      COL_WHITE: c = {8'd255, 8'd255, 8'd255};
      COL_BLUE:  c = {8'd0, 8'd0, 8'd255};
      COL_BLACK: c = {8'd0, 8'd0, 8'd0};
      COL_BROWN: c = {8'd153, 8'd102, 8'd51};
      default:   c = 24'd0;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/fop_cfg.sv */
module fop_cfg import fop_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [SideW-1:0] cfg_data_i,
  output cfg_t             cfg_o
);

  logic [SideW-1:0] side_q, side_d;
  logic [2:0]       shape_q, shape_d, color_q, color_d;
  logic [SqW-1:0]   circ2_q, lo2_q, q2_q, arc2_q;
  logic [SideW-1:0] s;
  logic [9:0]       c, q;
  logic signed [DiffW-1:0] cm1, qm5, qp20, qs;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    side_d  = side_q;
    shape_d = shape_q;
    color_d = color_q;
    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_SIDE:  side_d  = cfg_data_i;
        REG_SHAPE: shape_d = cfg_data_i[2:0];
        REG_COLOR: color_d = cfg_data_i[2:0];
        default:   ;
      endcase
    end
  end

  assign s    = (side_q > MaxSideVal) ? MaxSideVal : side_q;
  assign c    = s[10:1];
  assign q    = {1'b0, s[10:2]};
  assign cm1  = $signed({2'b0, c}) - 12'sd1;
  assign qm5  = $signed({2'b0, q}) - 12'sd5;
  assign qp20 = $signed({2'b0, q}) + 12'sd20;
  assign qs   = $signed({2'b0, q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q  <= SideW'(512);
      shape_q <= SHAPE_NONE;
      color_q <= COL_RED;
    end else begin
      side_q  <= side_d;
      shape_q <= shape_d;
      color_q <= color_d;
    end
  end

  // derived thresholds, registered from the stored side value after a write
  always_ff @(posedge clk_i) begin
    circ2_q <= sq_abs(cm1);
    lo2_q   <= sq_abs(qm5);
    q2_q    <= sq_abs(qs);
    arc2_q  <= sq_abs(qp20);
  end

  assign cfg_o = '{side: s, shape: shape_q, color: color_q,
                   circ2: circ2_q, lo2: lo2_q, q2: q2_q, arc2: arc2_q};

endmodule

/* hw/rtl/fop_geom.sv */
module fop_geom import fop_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  in_t    in_data_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output flags_t out_flags_o
);

  typedef struct packed {
    pix_t       pix;
    logic       in_img;
    logic       sq_hit;
    logic [3:0] rgate;
    logic [3:0] kgate;
    logic [3:0] bar;
  } lin_t;

  lin_t s1_q, s1_d, s2_q;
  logic [NumD-1:0][DiffW-1:0] dif_q, dif_d;
  logic [NumD-1:0][SqW-1:0]   sqr_q;
  flags_t s3_q, s3_d;
  logic v1_q, v2_q, v3_q, en1, en2, en3;

  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  // stage 1: linear compares and differences
  always_comb begin
    logic signed [12:0] x, y, s, q, t, h;
    logic a1, a2, a3, a4, b1, b2, b3, b4;
    x = $signed({3'b0, in_data_i.pos_x});
    y = $signed({3'b0, in_data_i.pos_y});
    s = $signed({2'b0, cfg_i.side});
    q = $signed({4'b0, cfg_i.side[10:2]});
    h = $signed({3'b0, cfg_i.side[10:1]});
    t = q + q + q;
    s1_d.pix    = '{r: in_data_i.red_in, g: in_data_i.green_in,
                    b: in_data_i.blue_in, a: in_data_i.alpha_in};
    s1_d.in_img = (x < s) && (y < s);
    s1_d.sq_hit = ((x < 13'sd30 || x > s - 13'sd30) && (y < 13'sd50 || y > s - 13'sd50))
                  || y < 13'sd15 || y > s - 13'sd15 || x < 13'sd15 || x > s - 13'sd15;
    a1 = x < q && y < h;
    a2 = x < q && y > h && y < s;
    a3 = x > t && x < s && y < h;
    a4 = x > t && x < s && y > h && y < s;
    b1 = y < q && x < h;
    b2 = y < q && x > h && x < s;
    b3 = y > t && y < s && x < h;
    b4 = y > t && y < s && x > h && x < s;
    s1_d.rgate = {a4 || b4, a3 || b2, a2 || b3, a1 || b1};
    s1_d.kgate[0] = y < q + 13'sd20 && x < q + 13'sd20;
    s1_d.kgate[1] = y < q + 13'sd20 && x >= t - 13'sd20;
    s1_d.kgate[2] = y >= t - 13'sd20 && x < q + 13'sd20;
    s1_d.kgate[3] = y >= t - 13'sd20 && x >= t - 13'sd20;
    s1_d.bar[0] = y < 13'sd20 && x >= q && x < t;
    s1_d.bar[1] = y >= q && y < t && x < 13'sd20;
    s1_d.bar[2] = y >= q && y < t && x >= s - 13'sd20;
    s1_d.bar[3] = y >= s - 13'sd20 && x >= q && x < t;
    dif_d[D_XC] = DiffW'(x - h);
    dif_d[D_YC] = DiffW'(y - h);
    dif_d[D_XQ] = DiffW'(x - q);
    dif_d[D_XT] = DiffW'(x - t);
    dif_d[D_YQ] = DiffW'(y - q);
    dif_d[D_YT] = DiffW'(y - t);
    dif_d[D_X]  = DiffW'(x);
    dif_d[D_Y]  = DiffW'(y);
    dif_d[D_SX] = DiffW'(s - x);
    dif_d[D_SY] = DiffW'(s - y);
  end

  // stage 3: distance sums against thresholds
  always_comb begin
    logic [SumW-1:0] d11, d12, d21, d22, dc;
    logic [3:0][SumW-1:0] dk;
    logic [SumW-1:0] lo, hi, ar;
    lo  = SumW'(cfg_i.lo2);
    hi  = SumW'(cfg_i.q2);
    ar  = SumW'(cfg_i.arc2);
    dc  = SumW'(sqr_q[D_XC]) + SumW'(sqr_q[D_YC]);
    d11 = SumW'(sqr_q[D_XQ]) + SumW'(sqr_q[D_YQ]);
    d12 = SumW'(sqr_q[D_XQ]) + SumW'(sqr_q[D_YT]);
    d21 = SumW'(sqr_q[D_XT]) + SumW'(sqr_q[D_YQ]);
    d22 = SumW'(sqr_q[D_XT]) + SumW'(sqr_q[D_YT]);
    dk[0] = SumW'(sqr_q[D_X])  + SumW'(sqr_q[D_Y]);
    dk[1] = SumW'(sqr_q[D_SX]) + SumW'(sqr_q[D_Y]);
    dk[2] = SumW'(sqr_q[D_X])  + SumW'(sqr_q[D_SY]);
    dk[3] = SumW'(sqr_q[D_SX]) + SumW'(sqr_q[D_SY]);
    s3_d.pix      = s2_q.pix;
    s3_d.in_img   = s2_q.in_img;
    s3_d.sq_hit   = s2_q.sq_hit;
    s3_d.circ_hit = dc >= SumW'(cfg_i.circ2);
    s3_d.ring_hit = (s2_q.rgate[0] && d11 <= hi && d11 >= lo)
                 || (s2_q.rgate[1] && d12 <= hi && d12 >= lo)
                 || (s2_q.rgate[2] && d21 <= hi && d21 >= lo)
                 || (s2_q.rgate[3] && d22 <= hi && d22 >= lo);
    for (int i = 0; i < 4; i++) begin
      s3_d.kcut[i]   = s2_q.kgate[i] && dk[i] <= hi;
      s3_d.kpaint[i] = s2_q.kgate[i] && dk[i] > hi && dk[i] <= ar;
    end
    s3_d.bar = s2_q.bar;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q  <= s1_d;
      dif_q <= dif_d;
    end
    if (en2) begin
      s2_q <= s1_q;
      for (int i = 0; i < NumD; i++) sqr_q[i] <= sq_abs(dif_q[i]);
    end
    if (en3) s3_q <= s3_d;
  end

  assign out_valid_o = v3_q;
  assign out_flags_o = s3_q;

endmodule

/* hw/rtl/fop_blend.sv */
module fop_blend import fop_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  flags_t in_flags_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output out_t   out_data_o
);

  logic valid_q, en;
  out_t out_q, out_d;

  assign en = !valid_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    logic [23:0] col;
    logic painted, cut, hit;
    col = color_rgb(cfg_i.color);
    painted = 1'b0;
    cut = 1'b0;
    // rounded: regions in order; a later paint or bar clears an earlier cut, a cut does not clear paint
    for (int i = 0; i < 4; i++) begin
      if (in_flags_i.kcut[i]) cut = 1'b1;
      else if (in_flags_i.kpaint[i]) begin
        painted = 1'b1;
        cut = 1'b0;
      end
      if (in_flags_i.bar[i]) begin
        painted = 1'b1;
        cut = 1'b0;
      end
    end
    case (shape_e'(cfg_i.shape))
      SHAPE_SQUARE:  hit = in_flags_i.sq_hit;
      SHAPE_CIRCLE:  hit = in_flags_i.circ_hit;
      SHAPE_RINGS:   hit = in_flags_i.ring_hit;
      SHAPE_ROUNDED: hit = painted;
      default:       hit = 1'b0;
    endcase
    if (cfg_i.shape != SHAPE_ROUNDED) cut = 1'b0;
    if (!in_flags_i.in_img) begin
      hit = 1'b0;
      cut = 1'b0;
    end
    out_d = '{red_out: in_flags_i.pix.r, green_out: in_flags_i.pix.g,
              blue_out: in_flags_i.pix.b, alpha_out: in_flags_i.pix.a};
    if (hit) out_d = {col, 8'd255};
    if (cut) out_d.alpha_out = 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (en) valid_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;

  a_outside_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && in_valid_i && !in_flags_i.in_img |=>
      out_q == $past({in_flags_i.pix.r, in_flags_i.pix.g, in_flags_i.pix.b, in_flags_i.pix.a}))
    else $error("outside pixel altered");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |=> valid_q && $stable(out_q))
    else $error("stalled result lost");

  a_circle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && in_valid_i && in_flags_i.in_img && in_flags_i.circ_hit &&
      cfg_i.shape == SHAPE_CIRCLE |=> out_q.alpha_out == 8'd255)
    else $error("circle frame missing");

endmodule

/* hw/rtl/frame_overlay_pixel.sv */
// Pipeline: three geometry stages and one output register between input request and result.
// Throughput: one pixel per cycle; stages stall independently, bubbles are squeezed out.
// Config thresholds are registered from the stored side value after a write to the side register.
// Reset: asynchronous active low; side 512, shape none, color red, pipeline empty.
module frame_overlay_pixel import fop_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [SideW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o
);

  cfg_t   cfg;
  flags_t flags;
  logic   g_valid, g_ready;

  fop_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .cfg_o(cfg)
  );

  fop_geom u_geom (
    .clk_i, .rst_ni, .cfg_i(cfg), .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o(g_valid), .out_ready_i(g_ready), .out_flags_o(flags)
  );

  fop_blend u_blend (
    .clk_i, .rst_ni, .cfg_i(cfg), .in_valid_i(g_valid), .in_ready_o(g_ready),
    .in_flags_i(flags), .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
